/* sv/nns_pkg.sv */
package nns_pkg;

    // fixed field widths
    localparam int COORD_W     = 16;
    localparam int DIM_W       = 4;
    localparam int NEAR_IDX_W  = 8;
    localparam int DIST_OUT_W  = 35;
    localparam int SUM_W       = 36;
    localparam int SQ_W        = 2 * COORD_W;

    // stream widths
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 64;
    localparam int M_TUSER_W   = 2;

    // defaults for the top level parameters
    localparam int MAX_ENTRIES_DEF = 256;
    localparam int MAX_DIM_DEF     = 8;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd2;

    // input kind carried in s_tuser
    localparam logic OP_REF   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // status carried in m_tuser[0]
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DRAIN,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_EMPTY
    } nns_state_t;

    // per-coordinate control that rides along the distance pipeline
    typedef struct packed {
        logic valid;
        logic first_entry;
        logic first_coord;
        logic last_coord;
    } nns_ctl_t;

endpackage

/* sv/nns_ref_mem.sv */
module nns_ref_mem
    import nns_pkg::*;
#(
    parameter int DEPTH  = MAX_ENTRIES_DEF * MAX_DIM_DEF,
    parameter int ADDR_W = $clog2(MAX_ENTRIES_DEF * MAX_DIM_DEF)
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [COORD_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [COORD_W-1:0] rd_data
);

    logic [COORD_W-1:0] mem [DEPTH];
    logic [COORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/nns_dist_unit.sv */
module nns_dist_unit
    import nns_pkg::*;
#(
    parameter int IDX_W = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  nns_ctl_t           ctl_i,
    input  logic [IDX_W-1:0]   idx_i,
    input  logic [COORD_W-1:0] q_i,
    input  logic [COORD_W-1:0] ref_i,     // memory data, arrives the cycle after ctl_i
    output logic               busy_o,
    output logic [SUM_W-1:0]   best_dist_o,
    output logic [IDX_W-1:0]   best_idx_o
);

    nns_ctl_t           ctl1_reg, ctl2_reg;
    logic [IDX_W-1:0]   idx1_reg, idx2_reg;
    logic [COORD_W-1:0] q1_reg;
    logic [COORD_W-1:0] diff;
    logic [SQ_W-1:0]    sq_next, sq_reg;
    logic [SUM_W-1:0]   acc_reg, acc_base, acc_next;
    logic [SUM_W:0]     sum_ext;
    logic [SUM_W-1:0]   best_dist_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic               take_best;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else begin
            ctl1_reg <= ctl_i;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg <= idx_i;
        idx2_reg <= idx1_reg;
        q1_reg   <= q_i;
        sq_reg   <= sq_next;
    end

    // stage 1: absolute difference and square
    always_comb begin
        diff    = (ref_i > q1_reg) ? (ref_i - q1_reg) : (q1_reg - ref_i);
        sq_next = {{COORD_W{1'b0}}, diff} * {{COORD_W{1'b0}}, diff};
    end

    // stage 2: saturating accumulate and keep the smallest sum
    always_comb begin
        acc_base  = ctl2_reg.first_coord ? '0 : acc_reg;
        sum_ext   = {1'b0, acc_base} + (SUM_W+1)'(sq_reg);
        acc_next  = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        take_best = ctl2_reg.valid && ctl2_reg.last_coord
                    && (ctl2_reg.first_entry || (acc_next < best_dist_reg));
    end

    always_ff @(posedge aclk) begin
        if (ctl2_reg.valid) begin
            acc_reg <= acc_next;
        end
        if (take_best) begin
            best_dist_reg <= acc_next;
            best_idx_reg  <= idx2_reg;
        end
    end

    assign busy_o      = ctl1_reg.valid | ctl2_reg.valid;
    assign best_dist_o = best_dist_reg;
    assign best_idx_o  = best_idx_reg;

endmodule

/* sv/nearest_neighbor_search.sv */
// nearest neighbor search over a table of reference points, squared distance
// input channel s_*: one coordinate per item, s_tuser says reference (0) or
//   query (1); a point or query completes after dim coordinates
// config channel cfg_*: writes dim (coordinates per point), always ready,
//   write only while no query is in progress
// result channel m_*: one item per coordinate of the nearest entry, m_tlast
//   on the final one; an empty table gives a single item with status set
// a reference coordinate or a partial query is stored as it is accepted; a completing
//   query walks entry_count * dim coordinates through the one multiply and
//   accumulate unit, one per cycle, then drains the pipeline, then reads
//   and loads each result item in turn while the receiver keeps up
// the rate is set by the single read port of the reference memory feeding
//   one squaring unit
// s_tready is low from query completion until the final result is loaded
//   into the output register; that item may wait there while new items enter
// a stalled receiver freezes the output register and the emit sequencer
// reset clears counts, positions, the dropped flag and the output valid;
//   the table itself is not cleared; only entries loaded since reset are read
module nearest_neighbor_search
    import nns_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int MAX_DIM     = MAX_DIM_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // config
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [DIM_W-1:0]     cfg_data,      // dim
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // coord[15:0]
    input  logic [S_TUSER_W-1:0] s_tuser,       // op[0]
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,       // near_coord[15:0], near_index[23:16],
                                                // near_dist_sq[58:24], zero pad
    output logic                 m_tlast,
    output logic [M_TUSER_W-1:0] m_tuser        // status[0], dropped[1]
);

    localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ENTRY_W = $clog2(MAX_ENTRIES + 1);
    localparam int POS_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIMC_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W   = (DIMC_W > DIM_W) ? DIMC_W : DIM_W;
    localparam int DEPTH   = MAX_ENTRIES * MAX_DIM;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PAD_W   = M_TDATA_W - COORD_W - NEAR_IDX_W - DIST_OUT_W;

    nns_state_t          state_reg, state_next;

    // config and load side
    logic [DIM_W-1:0]    dim_reg;
    logic [ENTRY_W-1:0]  entry_cnt_reg;
    logic [POS_W-1:0]    load_pos_reg;
    logic [POS_W-1:0]    q_pos_reg;
    logic [COORD_W-1:0]  qbuf_reg [MAX_DIM];
    logic                overflow_reg;

    // walk and emit counters
    logic [IDX_W-1:0]    e_reg;
    logic [POS_W-1:0]    i_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [POS_W-1:0]    o_i_reg;

    // output register
    logic                m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                m_last_reg;
    logic [M_TUSER_W-1:0] m_user_reg;

    logic [CMP_W-1:0]    dim_ext;
    logic [DIMC_W-1:0]   eff_dim;
    logic                s_accept;
    logic                ref_accept;
    logic                query_accept;
    logic                query_done;
    logic                table_full;
    logic                coord_last;
    logic                entry_last;
    logic                out_last;
    logic                slot_free;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [COORD_W-1:0]  mem_rdata;
    logic [ADDR_W-1:0]   best_base;

    nns_ctl_t            ctl;
    logic                dist_busy;
    logic [SUM_W-1:0]    best_dist;
    logic [IDX_W-1:0]    best_idx;
    logic [IDX_W+NEAR_IDX_W-1:0] best_idx_ext;

    logic                issue;
    logic                out_load;
    logic                empty_load;

    // effective dim: 0 acts as 1, anything above MAX_DIM acts as MAX_DIM
    always_comb begin
        dim_ext = CMP_W'(dim_reg);
        if (dim_reg == '0) begin
            eff_dim = DIMC_W'(1);
        end else if (dim_ext > CMP_W'(MAX_DIM)) begin
            eff_dim = DIMC_W'(MAX_DIM);
        end else begin
            eff_dim = DIMC_W'(dim_ext);
        end
    end

    assign cfg_ready    = 1'b1;
    assign s_accept     = s_tvalid & s_tready;
    assign ref_accept   = s_accept & (s_tuser[0] == OP_REF);
    assign query_accept = s_accept & (s_tuser[0] == OP_QUERY);
    assign query_done   = query_accept & ((DIMC_W'(q_pos_reg) + DIMC_W'(1)) >= eff_dim);
    assign table_full   = (entry_cnt_reg == ENTRY_W'(MAX_ENTRIES));
    assign coord_last   = ((DIMC_W'(i_reg) + DIMC_W'(1)) == eff_dim);
    assign entry_last   = ((ENTRY_W'(e_reg) + ENTRY_W'(1)) == entry_cnt_reg);
    assign out_last     = ((DIMC_W'(o_i_reg) + DIMC_W'(1)) == eff_dim);
    assign slot_free    = ~m_valid_reg | m_tready;

    // reference writes go to entry_count * MAX_DIM + load position
    assign mem_we    = ref_accept & ~table_full;
    assign mem_waddr = ADDR_W'(entry_cnt_reg[IDX_W-1:0]) * ADDR_W'(MAX_DIM)
                       + ADDR_W'(load_pos_reg);
    assign best_base = ADDR_W'(best_idx) * ADDR_W'(MAX_DIM);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (query_done) begin
                    state_next = (entry_cnt_reg == '0) ? ST_EMPTY : ST_CALC;
                end
            end
            ST_CALC: begin
                if (coord_last && entry_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!dist_busy) begin
                    state_next = ST_OUT_RD;
                end
            end
            ST_OUT_RD: begin
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                if (slot_free) begin
                    state_next = out_last ? ST_IDLE : ST_OUT_RD;
                end
            end
            ST_EMPTY: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready   = 1'b0;
        issue      = 1'b0;
        out_load   = 1'b0;
        empty_load = 1'b0;
        mem_raddr  = base_reg + ADDR_W'(i_reg);
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_CALC: begin
                issue = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_OUT_RD: begin
                mem_raddr = best_base + ADDR_W'(o_i_reg);
            end
            ST_OUT_LD: begin
                // keep reading the same cell while the receiver stalls
                mem_raddr = best_base + ADDR_W'(o_i_reg);
                out_load  = slot_free;
            end
            ST_EMPTY: begin
                empty_load = slot_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        ctl.valid       = issue;
        ctl.first_entry = (e_reg == '0);
        ctl.first_coord = (i_reg == '0);
        ctl.last_coord  = coord_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // config, table fill and query gather
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg       <= DIM_RESET;
            entry_cnt_reg <= '0;
            load_pos_reg  <= '0;
            q_pos_reg     <= '0;
            overflow_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                dim_reg <= cfg_data;
            end
            if (ref_accept) begin
                if (table_full) begin
                    overflow_reg <= 1'b1;
                end else if ((DIMC_W'(load_pos_reg) + DIMC_W'(1)) >= eff_dim) begin
                    load_pos_reg  <= '0;
                    entry_cnt_reg <= entry_cnt_reg + ENTRY_W'(1);
                end else begin
                    load_pos_reg <= load_pos_reg + POS_W'(1);
                end
            end
            if (query_accept) begin
                q_pos_reg <= query_done ? '0 : (q_pos_reg + POS_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (query_accept) begin
            qbuf_reg[q_pos_reg] <= s_tdata[COORD_W-1:0];
        end
    end

    // walk and emit counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_reg    <= '0;
            i_reg    <= '0;
            base_reg <= '0;
            o_i_reg  <= '0;
        end else begin
            if (query_done) begin
                e_reg    <= '0;
                i_reg    <= '0;
                base_reg <= '0;
                o_i_reg  <= '0;
            end else if (issue) begin
                if (coord_last) begin
                    i_reg    <= '0;
                    e_reg    <= e_reg + IDX_W'(1);
                    base_reg <= base_reg + ADDR_W'(MAX_DIM);
                end else begin
                    i_reg <= i_reg + POS_W'(1);
                end
            end else if (out_load) begin
                o_i_reg <= out_last ? '0 : (o_i_reg + POS_W'(1));
            end
        end
    end

    // output register
    assign best_idx_ext = {{NEAR_IDX_W{1'b0}}, best_idx};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load || empty_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {{PAD_W{1'b0}}, best_dist[DIST_OUT_W-1:0],
                           best_idx_ext[NEAR_IDX_W-1:0], mem_rdata};
            m_last_reg <= out_last;
            m_user_reg <= {overflow_reg, STATUS_OK};
        end else if (empty_load) begin
            m_data_reg <= '0;
            m_last_reg <= 1'b1;
            m_user_reg <= {overflow_reg, STATUS_EMPTY};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    nns_ref_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ref_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (s_tdata[COORD_W-1:0]),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    nns_dist_unit #(
        .IDX_W (IDX_W)
    ) u_dist_unit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl_i       (ctl),
        .idx_i       (e_reg),
        .q_i         (qbuf_reg[i_reg]),
        .ref_i       (mem_rdata),
        .busy_o      (dist_busy),
        .best_dist_o (best_dist),
        .best_idx_o  (best_idx)
    );

endmodule

/* sv/nns_checker.sv */
module nns_checker
    import nns_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // no result item right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // an empty-table answer is a single all-zero item
    a_empty_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == STATUS_EMPTY) |-> m_tlast && (m_tdata == '0))
        else $error("empty-table result malformed");

    // a reference load never blocks the next item
    a_ref_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == OP_REF) |=> s_tready)
        else $error("not ready after a reference load");

    // the dropped flag is sticky across results
    a_dropped_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser[1] ##1 m_tvalid |-> m_tuser[1])
        else $error("dropped flag cleared");

endmodule

bind nearest_neighbor_search nns_checker u_nns_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

/* verif/tb_nearest_neighbor_search.sv */
module tb_nearest_neighbor_search;
    timeunit 1ns;
    timeprecision 1ps;

    import nns_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 64;
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int IDLE_LIMIT    = 20000;
    localparam int REPORT_MAX    = 30;

    // result item layout
    localparam int IDX_LSB      = COORD_W;
    localparam int DIST_LSB     = COORD_W + NEAR_IDX_W;
    localparam int USER_STATUS  = 0;
    localparam int USER_DROPPED = 1;

    localparam logic [SUM_W-1:0] SUM_LIMIT = '1;

    typedef struct {
        logic [COORD_W-1:0]    near_coord;
        logic [NEAR_IDX_W-1:0] near_index;
        logic [DIST_OUT_W-1:0] near_dist_sq;
        logic                  last;
        logic                  status;
        logic                  dropped;
    } nn_answer_t;

    // clock, reset and the block's inputs, all known from time zero
    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tready  = 1'b0;

    logic                 cfg_ready;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic [M_TUSER_W-1:0] m_tuser;

    // mirror of the block: table, query buffer, positions, sticky flag, dim
    logic [COORD_W-1:0] ref_table    [MAX_ENTRIES_DEF][MAX_DIM_DEF];
    bit                 ref_filled   [MAX_ENTRIES_DEF][MAX_DIM_DEF];
    logic [COORD_W-1:0] query_coords [MAX_DIM_DEF];
    bit                 query_filled [MAX_DIM_DEF];
    int                 entry_total      = 0;
    int                 load_slot        = 0;
    int                 query_slot       = 0;
    bit                 table_overflowed = 1'b0;
    logic [DIM_W-1:0]   dim_setting      = DIM_RESET;

    nn_answer_t expected_answers[$];

    // traffic shaping
    bit tx_gaps_on      = 1'b0;
    bit rx_gaps_on      = 1'b0;
    int rx_hold_trigger = 0;
    int rx_hold_seen    = 0;
    int rx_wait_left    = 0;
    int phase_count     = 0;

    // bookkeeping
    int fail_count      = 0;
    int items_sent      = 0;
    int queries_done    = 0;
    int empty_answers   = 0;
    int answers_checked = 0;
    int quiet_cycles    = 0;

    nearest_neighbor_search u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #(HALF_PERIOD);
        aclk = 1'b1;
        #(HALF_PERIOD);
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // dim 0 acts as 1, anything above the maximum acts as the maximum
    function automatic int effective_dim();
        if (dim_setting == '0)
            return 1;
        if (dim_setting > MAX_DIM_DEF)
            return MAX_DIM_DEF;
        return int'(dim_setting);
    endfunction

    // sum of squared coordinate differences, saturating at the sum width
    function automatic logic [SUM_W-1:0] squared_distance(input int entry, input int d);
        logic [SUM_W-1:0]   sum;
        logic [COORD_W-1:0] a;
        logic [COORD_W-1:0] b;
        logic [COORD_W-1:0] diff;
        logic [SQ_W-1:0]    sq;
        sum = '0;
        for (int i = 0; i < d; i++) begin
            a    = ref_table[entry][i];
            b    = query_coords[i];
            diff = (a > b) ? a - b : b - a;
            sq   = SQ_W'(diff) * SQ_W'(diff);
            if (SUM_W'(sq) > SUM_LIMIT - sum)
                sum = SUM_LIMIT;
            else
                sum = sum + SUM_W'(sq);
        end
        return sum;
    endfunction

    // true when completing a query now reads only cells written since reset
    function automatic bit query_reads_written(input int d);
        for (int e = 0; e < entry_total; e++)
            for (int i = 0; i < d; i++)
                if (!ref_filled[e][i])
                    return 1'b0;
        for (int i = 0; i < d; i++)
            if (!query_filled[i] && i != query_slot && entry_total != 0)
                return 1'b0;
        return 1'b1;
    endfunction

    // applies one accepted coordinate and queues the answer it causes
    function automatic void apply_coordinate(input logic op, input logic [COORD_W-1:0] c);
        int               d;
        int               best;
        logic [SUM_W-1:0] best_sum;
        logic [SUM_W-1:0] sum;
        nn_answer_t       ans;
        d = effective_dim();
        if (op == OP_REF) begin
            if (entry_total >= MAX_ENTRIES_DEF) begin
                table_overflowed = 1'b1;
                return;
            end
            ref_table[entry_total][load_slot]  = c;
            ref_filled[entry_total][load_slot] = 1'b1;
            if (load_slot + 1 >= d) begin
                load_slot = 0;
                entry_total++;
            end else begin
                load_slot++;
            end
            return;
        end
        query_coords[query_slot] = c;
        query_filled[query_slot] = 1'b1;
        if (query_slot + 1 < d) begin
            query_slot++;
            return;
        end
        query_slot = 0;
        queries_done++;
        ans.dropped = table_overflowed;
        if (entry_total == 0) begin
            ans.near_coord   = '0;
            ans.near_index   = '0;
            ans.near_dist_sq = '0;
            ans.last         = 1'b1;
            ans.status       = STATUS_EMPTY;
            expected_answers = {expected_answers, ans};
            empty_answers++;
            return;
        end
        // strict less-than keeps the lower index on a tie
        best     = 0;
        best_sum = squared_distance(0, d);
        for (int e = 1; e < entry_total; e++) begin
            sum = squared_distance(e, d);
            if (sum < best_sum) begin
                best_sum = sum;
                best     = e;
            end
        end
        for (int i = 0; i < d; i++) begin
            ans.near_coord   = ref_table[best][i];
            ans.near_index   = NEAR_IDX_W'(best);
            ans.near_dist_sq = best_sum[DIST_OUT_W-1:0];
            ans.last         = (i == d - 1);
            ans.status       = STATUS_OK;
            expected_answers = {expected_answers, ans};
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // field extremes often, otherwise any value
    function automatic logic [COORD_W-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return COORD_W'($urandom_range(0, 65535));
    endfunction

    // offers one item and waits for it to be taken; valid stays high on return
    task automatic send_item(input logic op, input logic [COORD_W-1:0] coord);
        int   gap;
        logic kind;
        kind = op;
        // a query that would read a never-written cell goes in as a reference load
        if (kind == OP_QUERY && query_slot + 1 >= effective_dim()
                && !query_reads_written(effective_dim()))
            kind = OP_REF;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= coord;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_coordinate(kind, coord);
        items_sent++;
    endtask

    // drops valid and waits until every queued answer has come back
    task automatic wait_answers_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_answers.size() != 0) @(posedge aclk);
    endtask

    // dim is only written with the block idle
    task automatic set_dim(input logic [DIM_W-1:0] value);
        wait_answers_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        dim_setting = value;
        cfg_valid <= 1'b0;
    endtask

    // finish any half-loaded point and half-gathered query
    task automatic align_points();
        while (load_slot != 0) send_item(OP_REF, pick_coord());
        while (query_slot != 0) send_item(OP_QUERY, pick_coord());
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("mismatch at %0t, result %0d: %s got 0x%0h expected 0x%0h",
                     $time, answers_checked, what, got, want);
    endtask

    task automatic check_answer();
        nn_answer_t want;
        logic [COORD_W-1:0]    got_coord;
        logic [NEAR_IDX_W-1:0] got_index;
        logic [DIST_OUT_W-1:0] got_dist;
        got_coord = m_tdata[IDX_LSB-1:0];
        got_index = m_tdata[DIST_LSB-1:IDX_LSB];
        got_dist  = m_tdata[DIST_LSB+DIST_OUT_W-1:DIST_LSB];
        answers_checked++;
        if (expected_answers.size() == 0) begin
            report_mismatch("result item with nothing expected", got_coord, 0);
            return;
        end
        want = expected_answers.pop_front();
        if (got_coord !== want.near_coord)
            report_mismatch("near_coord", got_coord, want.near_coord);
        if (got_index !== want.near_index)
            report_mismatch("near_index", got_index, want.near_index);
        if (got_dist !== want.near_dist_sq)
            report_mismatch("near_dist_sq", got_dist, want.near_dist_sq);
        if (m_tlast !== want.last)
            report_mismatch("last", m_tlast, want.last);
        if (m_tuser[USER_STATUS] !== want.status)
            report_mismatch("status", m_tuser[USER_STATUS], want.status);
        if (m_tuser[USER_DROPPED] !== want.dropped)
            report_mismatch("dropped", m_tuser[USER_DROPPED], want.dropped);
    endtask

    // receiver: checks at the edge, then picks the next ready value
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_answer();
        if (rx_hold_trigger != rx_hold_seen) begin
            rx_hold_seen = rx_hold_trigger;
            rx_wait_left = HOLD_CYCLES;
        end
        if (rx_wait_left > 0) begin
            rx_wait_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn;
            if (rx_gaps_on && $urandom_range(0, 3) == 0)
                rx_wait_left = pick_gap();
        end
    end

    // watchdog: counts cycles in which no channel moves an item
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: nothing moved for %0d cycles, %0d answers outstanding",
                     IDLE_LIMIT, expected_answers.size());
            $display("** nearest_neighbor_search: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // a query on the empty table right after reset, with the reset dim
    task automatic test_empty_table();
        send_item(OP_QUERY, 16'h00FF);
        send_item(OP_QUERY, 16'hFF00);
    endtask

    // dim above the maximum acts as the maximum; largest possible distance
    task automatic test_extreme_distance();
        set_dim(4'd15);
        repeat (MAX_DIM_DEF) send_item(OP_REF, 16'hFFFF);
        repeat (MAX_DIM_DEF) send_item(OP_QUERY, 16'h0000);
    endtask

    // well-formed points and queries with random content, some stray items
    task automatic test_random_traffic(input logic [DIM_W-1:0] dim_value, input int budget);
        int   d;
        int   start;
        int   pick;
        int   src;
        bit   paused;
        bit   exact;
        logic [COORD_W-1:0] c;
        set_dim(dim_value);
        tx_gaps_on = (phase_count % 3 != 0);
        rx_gaps_on = (phase_count % 4 != 1);
        phase_count++;
        d      = effective_dim();
        start  = items_sent;
        paused = 1'b0;
        while (items_sent - start < budget) begin
            // sender pause midway until every answer is back
            if (!paused && items_sent - start >= budget / 2) begin
                wait_answers_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                for (int i = 0; i < d; i++) send_item(OP_REF, pick_coord());
            end else if (pick < 88) begin
                // half the queries land on or next to a stored point
                src   = (entry_total > 0 && $urandom_range(0, 1)) ?
                        $urandom_range(0, entry_total - 1) : -1;
                exact = $urandom_range(0, 1);
                for (int i = 0; i < d; i++) begin
                    if (src >= 0 && ref_filled[src][i])
                        c = exact ? ref_table[src][i]
                                  : ref_table[src][i] ^ COORD_W'($urandom_range(0, 7));
                    else
                        c = pick_coord();
                    send_item(OP_QUERY, c);
                end
            end else begin
                send_item($urandom_range(0, 1) ? OP_QUERY : OP_REF, pick_coord());
            end
        end
    endtask

    // receiver holds off while queries keep coming, so the input stalls
    task automatic test_receiver_hold_off();
        int d;
        wait_answers_drained();
        align_points();
        tx_gaps_on = 1'b0;
        d = effective_dim();
        rx_hold_trigger++;
        repeat (3)
            for (int i = 0; i < d; i++) send_item(OP_QUERY, pick_coord());
        for (int i = 0; i < d; i++) send_item(OP_REF, pick_coord());
    endtask

    // dim lowered while a point and a query are half gathered
    task automatic test_dim_change_mid_point();
        set_dim(4'd3);
        align_points();
        send_item(OP_REF, 16'h0102);
        send_item(OP_REF, 16'hFEFD);
        send_item(OP_QUERY, 16'h0100);
        send_item(OP_QUERY, 16'hFF00);
        set_dim(4'd2);
        // position already past the new dim: both close on the next item
        send_item(OP_REF, 16'h7F80);
        send_item(OP_QUERY, 16'h8000);
    endtask

    // two identical entries: the lower index must win
    task automatic test_equal_distance_tie();
        set_dim(4'd2);
        align_points();
        repeat (2) begin
            send_item(OP_REF, 16'h1357);
            send_item(OP_REF, 16'hECA8);
        end
        send_item(OP_QUERY, 16'h1357);
        send_item(OP_QUERY, 16'hECA8);
    endtask

    // fill the table, query it full, then lose loads and see the sticky flag
    task automatic test_full_table();
        set_dim(4'd1);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b1;
        while (entry_total < MAX_ENTRIES_DEF) send_item(OP_REF, pick_coord());
        send_item(OP_QUERY, ref_table[MAX_ENTRIES_DEF-1][0]);
        repeat (3) send_item(OP_REF, pick_coord());
        send_item(OP_QUERY, pick_coord());
        send_item(OP_QUERY, 16'hFFFF);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        test_empty_table();
        test_extreme_distance();

        // random, dims only go down so every stored cell stays readable
        test_random_traffic(4'd12, 10);
        test_random_traffic(4'd7, 8);
        test_random_traffic(4'd5, 8);
        test_dim_change_mid_point();
        test_equal_distance_tie();
        test_receiver_hold_off();
        test_random_traffic(4'd2, 8);
        test_random_traffic(4'd0, 10);
        test_random_traffic(4'd1, 10);
        test_full_table();

        wait_answers_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_answers.size() != 0)
            report_mismatch("answers never delivered", expected_answers.size(), 0);

        $display("covered %0d input items, %0d queries (%0d on an empty table), %0d results",
                 items_sent, queries_done, empty_answers, answers_checked);
        $display("dim settings 15, 12, 7, 5, 3, 2, 1 and 0, %0d entries, lost loads %0s",
                 entry_total, table_overflowed ? "seen" : "not seen");
        if (fail_count == 0) begin
            $display("** nearest_neighbor_search: PASSED **");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("** nearest_neighbor_search: FAILED **");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/nns_pkg.sv
sv/nns_ref_mem.sv
sv/nns_dist_unit.sv
sv/nearest_neighbor_search.sv
sv/nns_checker.sv
verif/tb_nearest_neighbor_search.sv
